// ===== hdl/assert_macros.svh =====
// assertion macros used by the queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/q4sd_pkg.sv =====
// shared types and constants of the quad4 strain-displacement block
package q4sd_pkg;

  localparam int NODES         = 4;
  localparam int DERIV_WIDTH   = 32;
  localparam int DET_WIDTH     = 48;
  localparam int DET_FRAC_BITS = 16;
  localparam int QUARTER_SHIFT = 2;
  localparam int QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic signed [15:0] s_coord;
    logic signed [15:0] t_coord;
    logic signed [23:0] node_x0;
    logic signed [23:0] node_x1;
    logic signed [23:0] node_x2;
    logic signed [23:0] node_x3;
    logic signed [23:0] node_y0;
    logic signed [23:0] node_y1;
    logic signed [23:0] node_y2;
    logic signed [23:0] node_y3;
  } in_word_t;

  typedef struct packed {
    logic signed [DERIV_WIDTH-1:0] dndx0;
    logic signed [DERIV_WIDTH-1:0] dndx1;
    logic signed [DERIV_WIDTH-1:0] dndx2;
    logic signed [DERIV_WIDTH-1:0] dndx3;
    logic signed [DERIV_WIDTH-1:0] dndy0;
    logic signed [DERIV_WIDTH-1:0] dndy1;
    logic signed [DERIV_WIDTH-1:0] dndy2;
    logic signed [DERIV_WIDTH-1:0] dndy3;
    logic signed [DET_WIDTH-1:0]   det_jac;
    logic                          singular;
  } out_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/quad4_strain_displacement.sv =====
// top level of the quad4 strain-displacement (b matrix) block
// Takes one natural point (s,t) in Q2.14 and the four corner coordinates of a
// bilinear quad and returns the eight global shape derivatives dNi/dx, dNi/dy
// in Q8.24 (rounded to nearest, ties away from zero, saturated), the jacobian
// determinant with 16 fraction bits (rounded, saturated) and a singular flag.
// A zero determinant gives zero derivatives, zero det_jac and singular set.
// One word is accepted every cycle while the queue has room. The restoring divider in
// the back pipeline spends one stage on each of the 34 quotient bits (overflow bit,
// 32 result bits and one rounding bit).
// The front pipeline (5 stages: shape terms, jacobian sums, split multipliers,
// determinant and numerators) feeds a four-word queue so it only holds its
// input when the queue fills; the back pipeline stops only when out_stall
// holds a finished word in the output register.
module quad4_strain_displacement #(
  parameter int COORD_BITS      = 24,
  parameter int NAT_FRAC_BITS   = 14,
  parameter int DERIV_FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  q4sd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output q4sd_pkg::out_word_t out_data
);
  import q4sd_pkg::*;

  // width of the shape derivative terms (times four)
  localparam int NW = (NAT_FRAC_BITS > 15 ? NAT_FRAC_BITS : 15) + 2;
  // jacobian entries, determinant, derivative numerators
  localparam int PW = NW + COORD_BITS + 2;
  localparam int DW = 2*PW + 1;
  localparam int UW = NW + PW + 1;
  // queue word: singular flag, determinant, eight numerators
  localparam int QW = DW + 2*NODES*UW + 1;

  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic [QW-1:0] pop_data;
  q_stat_t       q_stat;

  // front: forms the jacobian and classifies singular points
  q4sd_front #(
    .CW(COORD_BITS), .NF(NAT_FRAC_BITS), .NW(NW), .PW(PW), .DW(DW), .UW(UW), .QW(QW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .push(push),
    .push_data(push_data),
    .q_stat(q_stat)
  );

  // decoupling queue
  q4sd_queue #(.W(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(push_data),
    .pop(pop),
    .dout(pop_data),
    .stat(q_stat)
  );

  // back: divides by the determinant and formats the result word
  q4sd_back #(
    .NF(NAT_FRAC_BITS), .FB(DERIV_FRAC_BITS), .DW(DW), .UW(UW), .QW(QW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .pop_data(pop_data),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

// ===== hdl/q4sd_mul.sv =====
// two-stage signed multiplier, second operand split into two partial products
module q4sd_mul #(
  parameter int AW = 17,
  parameter int BW = 43
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  localparam int H   = BW / 2;
  localparam int LW  = AW + H + 1;
  localparam int HW  = AW + BW - H;
  localparam int PW2 = AW + BW;

  logic signed [H:0]      b_lo;
  logic signed [BW-H-1:0] b_hi;
  logic signed [LW-1:0]   p_lo;
  logic signed [HW-1:0]   p_hi;

  assign b_lo = $signed({1'b0, b[H-1:0]});
  assign b_hi = $signed(b[BW-1:H]);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= LW'(a) * LW'(b_lo);
      p_hi <= HW'(a) * HW'(b_hi);
      p    <= (PW2'(p_hi) <<< H) + PW2'(p_lo);
    end
  end

endmodule

// ===== hdl/q4sd_front.sv =====
// front pipeline: shape derivatives, jacobian, determinant, numerators, singular flag
module q4sd_front #(
  parameter int CW = 24,
  parameter int NF = 14,
  parameter int NW = 17,
  parameter int PW = 43,
  parameter int DW = 87,
  parameter int UW = 61,
  parameter int QW = 576
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  q4sd_pkg::in_word_t in_data,
  output logic               push,
  output logic [QW-1:0]      push_data,
  input  q4sd_pkg::q_stat_t  q_stat
);
  import q4sd_pkg::*;

  localparam int XW = NW + CW;
  localparam logic signed [NW-1:0] ONE = {{(NW-NF-1){1'b0}}, 1'b1, {NF{1'b0}}};

  logic en;
  logic v_a, v_b, v_c, v_d, v_e;

  logic signed [NW-1:0] s_ext, t_ext;
  logic signed [NW-1:0] n_c [NODES];
  logic signed [NW-1:0] m_c [NODES];
  logic signed [CW-1:0] x_c [NODES];
  logic signed [CW-1:0] y_c [NODES];

  logic signed [XW-1:0] pnx_a [NODES];
  logic signed [XW-1:0] pmx_a [NODES];
  logic signed [XW-1:0] pny_a [NODES];
  logic signed [XW-1:0] pmy_a [NODES];
  logic signed [NW-1:0] n_a [NODES];
  logic signed [NW-1:0] m_a [NODES];

  logic signed [PW-1:0] pxs_b, pxt_b, pys_b, pyt_b;
  logic signed [NW-1:0] n_b [NODES];
  logic signed [NW-1:0] m_b [NODES];

  logic signed [2*PW-1:0]  det_pa, det_pb;
  logic signed [NW+PW-1:0] nxa [NODES];
  logic signed [NW+PW-1:0] nxb [NODES];
  logic signed [NW+PW-1:0] nya [NODES];
  logic signed [NW+PW-1:0] nyb [NODES];

  logic signed [DW-1:0] det_e;
  logic signed [UW-1:0] numx_e [NODES];
  logic signed [UW-1:0] numy_e [NODES];
  logic                 sing_e;

  assign en       = !(v_e && q_stat.full);
  assign in_stall = !en;
  assign push     = v_e && !q_stat.full;

  // four times the shape derivatives
  always_comb begin
    s_ext  = NW'(in_data.s_coord);
    t_ext  = NW'(in_data.t_coord);
    n_c[0] = t_ext - ONE;
    n_c[1] = ONE - t_ext;
    n_c[2] = t_ext + ONE;
    n_c[3] = -(t_ext + ONE);
    m_c[0] = s_ext - ONE;
    m_c[1] = -(s_ext + ONE);
    m_c[2] = s_ext + ONE;
    m_c[3] = ONE - s_ext;
    x_c[0] = $signed(CW'($unsigned(in_data.node_x0)));
    x_c[1] = $signed(CW'($unsigned(in_data.node_x1)));
    x_c[2] = $signed(CW'($unsigned(in_data.node_x2)));
    x_c[3] = $signed(CW'($unsigned(in_data.node_x3)));
    y_c[0] = $signed(CW'($unsigned(in_data.node_y0)));
    y_c[1] = $signed(CW'($unsigned(in_data.node_y1)));
    y_c[2] = $signed(CW'($unsigned(in_data.node_y2)));
    y_c[3] = $signed(CW'($unsigned(in_data.node_y3)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NODES; i++) begin
        pnx_a[i] <= XW'(n_c[i]) * XW'(x_c[i]);
        pmx_a[i] <= XW'(m_c[i]) * XW'(x_c[i]);
        pny_a[i] <= XW'(n_c[i]) * XW'(y_c[i]);
        pmy_a[i] <= XW'(m_c[i]) * XW'(y_c[i]);
        n_a[i]   <= n_c[i];
        m_a[i]   <= m_c[i];
        n_b[i]   <= n_a[i];
        m_b[i]   <= m_a[i];
      end
      pxs_b <= PW'(pnx_a[0]) + PW'(pnx_a[1]) + PW'(pnx_a[2]) + PW'(pnx_a[3]);
      pxt_b <= PW'(pmx_a[0]) + PW'(pmx_a[1]) + PW'(pmx_a[2]) + PW'(pmx_a[3]);
      pys_b <= PW'(pny_a[0]) + PW'(pny_a[1]) + PW'(pny_a[2]) + PW'(pny_a[3]);
      pyt_b <= PW'(pmy_a[0]) + PW'(pmy_a[1]) + PW'(pmy_a[2]) + PW'(pmy_a[3]);
    end
  end

  q4sd_mul #(.AW(PW), .BW(PW)) u_det_a (.clk(clk), .en(en), .a(pxs_b), .b(pyt_b), .p(det_pa));
  q4sd_mul #(.AW(PW), .BW(PW)) u_det_b (.clk(clk), .en(en), .a(pxt_b), .b(pys_b), .p(det_pb));

  for (genvar i = 0; i < NODES; i++) begin : g_node
    q4sd_mul #(.AW(NW), .BW(PW)) u_nx_a (.clk(clk), .en(en), .a(n_b[i]), .b(pyt_b), .p(nxa[i]));
    q4sd_mul #(.AW(NW), .BW(PW)) u_nx_b (.clk(clk), .en(en), .a(m_b[i]), .b(pys_b), .p(nxb[i]));
    q4sd_mul #(.AW(NW), .BW(PW)) u_ny_a (.clk(clk), .en(en), .a(m_b[i]), .b(pxs_b), .p(nya[i]));
    q4sd_mul #(.AW(NW), .BW(PW)) u_ny_b (.clk(clk), .en(en), .a(n_b[i]), .b(pxt_b), .p(nyb[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_e  <= DW'(det_pa) - DW'(det_pb);
      sing_e <= (det_pa == det_pb);
      for (int i = 0; i < NODES; i++) begin
        numx_e[i] <= UW'(nxa[i]) - UW'(nxb[i]);
        numy_e[i] <= UW'(nya[i]) - UW'(nyb[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      push_data[i*UW +: UW]         = numx_e[i];
      push_data[(NODES+i)*UW +: UW] = numy_e[i];
    end
    push_data[2*NODES*UW +: DW] = det_e;
    push_data[QW-1]             = sing_e;
  end

endmodule

// ===== hdl/q4sd_queue.sv =====
// short queue between the front and back pipelines
`include "assert_macros.svh"

module q4sd_queue #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [W-1:0]      din,
  input  logic              pop,
  output logic [W-1:0]      dout,
  output q4sd_pkg::q_stat_t stat
);
  import q4sd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign dout       = mem[rp];
  assign stat.full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  `ASSERT_NEVER(a_q_overflow, clk, rst, push && stat.full, "queue written while full")
  `ASSERT_NEVER(a_q_underflow, clk, rst, pop && stat.empty, "queue read while empty")
  `ASSERT_PROP(a_q_count, clk, rst, (push == pop) |=> $stable(count), "queue count moved")

endmodule

// ===== hdl/q4sd_div.sv =====
// restoring divider, one quotient bit per stage, lanes share the divisor
module q4sd_div #(
  parameter int DW    = 87,
  parameter int NPW   = 86,
  parameter int QN    = 34,
  parameter int LANES = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DW-1:0]   den,
  input  logic [NPW-1:0]  num [LANES],
  output logic [QN-1:0]   quo [LANES]
);
  localparam int RW = (DW + QN > NPW) ? DW + QN : NPW;

  logic [DW-1:0] den_s [QN];
  logic [RW-1:0] rem_s [QN-1][LANES];
  logic [QN-1:0] quo_s [QN][LANES];

  for (genvar st = 0; st < QN; st++) begin : g_stage
    localparam int J = QN - 1 - st;
    logic [DW-1:0] d_prev;
    logic [RW-1:0] r_prev [LANES];
    logic [QN-1:0] q_prev [LANES];
    logic [RW-1:0] dsh;

    if (st == 0) begin : g_first
      assign d_prev = den;
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign r_prev[l] = RW'(num[l]);
        assign q_prev[l] = '0;
      end
    end else begin : g_next
      assign d_prev = den_s[st-1];
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign r_prev[l] = rem_s[st-1][l];
        assign q_prev[l] = quo_s[st-1][l];
      end
    end

    assign dsh = RW'(d_prev) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[st] <= d_prev;
        for (int l = 0; l < LANES; l++) begin
          if (r_prev[l] >= dsh) begin
            quo_s[st][l] <= q_prev[l] | (QN'(1) << J);
          end else begin
            quo_s[st][l] <= q_prev[l];
          end
        end
      end
    end

    if (st < QN - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem_s[st][l] <= (r_prev[l] >= dsh) ? r_prev[l] - dsh : r_prev[l];
          end
        end
      end
    end
  end

  assign quo = quo_s[QN-1];

endmodule

// ===== hdl/q4sd_back.sv =====
// back pipeline: magnitudes, division, rounding, saturation, output register
module q4sd_back #(
  parameter int NF = 14,
  parameter int FB = 24,
  parameter int DW = 87,
  parameter int UW = 61,
  parameter int QW = 576
) (
  input  logic                clk,
  input  logic                rst,
  input  q4sd_pkg::q_stat_t   q_stat,
  input  logic [QW-1:0]       pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output q4sd_pkg::out_word_t out_data
);
  import q4sd_pkg::*;

  localparam int K     = 2*NF + 2*QUARTER_SHIFT - DET_FRAC_BITS;
  localparam int NPW   = UW + FB + 1;
  localparam int QN    = DERIV_WIDTH + 2;
  localparam int LANES = 2 * NODES;
  localparam logic signed [DW:0] RND  = (DW+1)'(1) << (K-1);
  localparam logic signed [DW:0] DMAX = {{(DW+2-DET_WIDTH){1'b0}}, {(DET_WIDTH-1){1'b1}}};
  localparam logic signed [DW:0] DMIN = {{(DW+2-DET_WIDTH){1'b1}}, {(DET_WIDTH-1){1'b0}}};
  localparam logic [QN-2:0] LIM = (QN-1)'(1) << (DERIV_WIDTH-1);

  logic en;

  logic signed [DW-1:0] det_q;
  logic signed [UW-1:0] num_q [LANES];
  logic [UW-1:0]        nmag  [LANES];
  logic [NPW-1:0]       nump_c [LANES];
  logic [LANES-1:0]     neg_c;
  logic [DW-1:0]        den_c;
  logic signed [DW:0]   dsum, dshift;
  logic [DET_WIDTH-1:0] djac_c;

  logic [DW-1:0]        den_f;
  logic [NPW-1:0]       num_f [LANES];
  logic [QN-1:0]        quo_d [LANES];

  logic                 v_p    [QN+1];
  logic [LANES-1:0]     neg_p  [QN+1];
  logic                 sing_p [QN+1];
  logic [DET_WIDTH-1:0] djac_p [QN+1];

  logic [DERIV_WIDTH-1:0] res [LANES];
  out_word_t              out_c;

  function automatic logic [DERIV_WIDTH-1:0] sat_deriv(input logic [QN-1:0] q,
                                                       input logic neg);
    logic [QN-1:0] inc;
    logic [QN-2:0] mag;
    logic [DERIV_WIDTH-1:0] r;
    inc = {1'b0, q[QN-2:0]} + QN'(1);
    mag = inc[QN-1:1];
    if (neg) begin
      if (q[QN-1] || mag > LIM) r = {1'b1, {(DERIV_WIDTH-1){1'b0}}};
      else r = -mag[DERIV_WIDTH-1:0];
    end else begin
      if (q[QN-1] || mag >= LIM) r = {1'b0, {(DERIV_WIDTH-1){1'b1}}};
      else r = mag[DERIV_WIDTH-1:0];
    end
    return r;
  endfunction

  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_stat.empty;

  // unpack, take magnitudes, round and saturate the determinant
  always_comb begin
    det_q = $signed(pop_data[2*NODES*UW +: DW]);
    den_c = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    for (int l = 0; l < LANES; l++) begin
      num_q[l]  = $signed(pop_data[l*UW +: UW]);
      nmag[l]   = num_q[l][UW-1] ? UW'(-num_q[l]) : UW'(num_q[l]);
      nump_c[l] = NPW'(nmag[l]) << (FB + 1);
      neg_c[l]  = num_q[l][UW-1] ^ det_q[DW-1];
    end
    dsum   = (DW+1)'(det_q) + RND;
    dshift = dsum >>> K;
    if (dshift > DMAX) djac_c = {1'b0, {(DET_WIDTH-1){1'b1}}};
    else if (dshift < DMIN) djac_c = {1'b1, {(DET_WIDTH-1){1'b0}}};
    else djac_c = dshift[DET_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QN; i++) v_p[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_p[0] <= pop;
      for (int i = 1; i <= QN; i++) v_p[i] <= v_p[i-1];
      out_valid <= v_p[QN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_f     <= den_c;
      num_f     <= nump_c;
      neg_p[0]  <= neg_c;
      sing_p[0] <= pop_data[QW-1];
      djac_p[0] <= djac_c;
      for (int i = 1; i <= QN; i++) begin
        neg_p[i]  <= neg_p[i-1];
        sing_p[i] <= sing_p[i-1];
        djac_p[i] <= djac_p[i-1];
      end
      out_data <= out_c;
    end
  end

  q4sd_div #(.DW(DW), .NPW(NPW), .QN(QN), .LANES(LANES)) u_div (
    .clk(clk),
    .en(en),
    .den(den_f),
    .num(num_f),
    .quo(quo_d)
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res[l] = sing_p[QN] ? '0 : sat_deriv(quo_d[l], neg_p[QN][l]);
    end
    out_c.dndx0    = res[0];
    out_c.dndx1    = res[1];
    out_c.dndx2    = res[2];
    out_c.dndx3    = res[3];
    out_c.dndy0    = res[4];
    out_c.dndy1    = res[5];
    out_c.dndy2    = res[6];
    out_c.dndy3    = res[7];
    out_c.det_jac  = sing_p[QN] ? '0 : djac_p[QN];
    out_c.singular = sing_p[QN];
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the quad4 strain-displacement block: scoreboard, drivers, checks
`timescale 1ns / 100ps

import q4sd_pkg::*;

// holds predicted b-matrix words and compares them with what the block returns
class b_matrix_board;
  out_word_t pending_q[$];
  int        errors;
  int        seen;
  int        singular_seen;

  function new();
    errors        = 0;
    seen          = 0;
    singular_seen = 0;
  endfunction

  // clamp a wide signed value to a signed field of the given width
  function logic signed [127:0] clamp(logic signed [127:0] v, int bits);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    lo = -(128'sd1 <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // num * 2^24 / den, nearest with ties away from zero, clamped to 32 bits
  function logic signed [31:0] deriv_div(logic signed [127:0] num,
                                         logic signed [127:0] den);
    logic [127:0]        nm;
    logic [127:0]        dm;
    logic [127:0]        q;
    logic [127:0]        r;
    logic signed [127:0] sq;
    nm = (num < 0) ? -num : num;
    nm = nm << 24;
    dm = (den < 0) ? -den : den;
    q  = nm / dm;
    r  = nm % dm;
    if ((r << 1) >= dm) q = q + 1;
    sq = ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    sq = clamp(sq, 32);
    return sq[31:0];
  endfunction

  function out_word_t predict_b_matrix(in_word_t w);
    logic signed [127:0] s, t, one;
    logic signed [127:0] n[4];
    logic signed [127:0] m[4];
    logic signed [127:0] x[4];
    logic signed [127:0] y[4];
    logic signed [127:0] pxs, pxt, pys, pyt, det, dj;
    out_word_t           o;
    s = w.s_coord;
    t = w.t_coord;
    one = 128'sd16384;
    x[0] = w.node_x0; x[1] = w.node_x1; x[2] = w.node_x2; x[3] = w.node_x3;
    y[0] = w.node_y0; y[1] = w.node_y1; y[2] = w.node_y2; y[3] = w.node_y3;
    // four times dN/ds and dN/dt
    n[0] = t - one; n[1] = one - t; n[2] = t + one; n[3] = -(t + one);
    m[0] = s - one; m[1] = -(s + one); m[2] = s + one; m[3] = one - s;
    pxs = 0; pxt = 0; pys = 0; pyt = 0;
    for (int i = 0; i < NODES; i++) begin
      pxs += n[i] * x[i];
      pxt += m[i] * x[i];
      pys += n[i] * y[i];
      pyt += m[i] * y[i];
    end
    det = pxs * pyt - pxt * pys;
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    o.dndx0 = deriv_div(n[0] * pyt - m[0] * pys, det);
    o.dndx1 = deriv_div(n[1] * pyt - m[1] * pys, det);
    o.dndx2 = deriv_div(n[2] * pyt - m[2] * pys, det);
    o.dndx3 = deriv_div(n[3] * pyt - m[3] * pys, det);
    o.dndy0 = deriv_div(m[0] * pxs - n[0] * pxt, det);
    o.dndy1 = deriv_div(m[1] * pxs - n[1] * pxt, det);
    o.dndy2 = deriv_div(m[2] * pxs - n[2] * pxt, det);
    o.dndy3 = deriv_div(m[3] * pxs - n[3] * pxt, det);
    // det carries 32 fraction bits here, the port keeps 16
    dj = clamp((det + (128'sd1 <<< 15)) >>> 16, 48);
    o.det_jac  = dj[47:0];
    o.singular = 1'b0;
    return o;
  endfunction

  function void note_input(in_word_t w);
    pending_q.push_back(predict_b_matrix(w));
  endfunction

  function void cmp(string name, logic signed [63:0] exp_v, logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(out_word_t a);
    out_word_t e;
    if (pending_q.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    e = pending_q.pop_front();
    seen++;
    if (e.singular) singular_seen++;
    cmp("dndx0", e.dndx0, a.dndx0);
    cmp("dndx1", e.dndx1, a.dndx1);
    cmp("dndx2", e.dndx2, a.dndx2);
    cmp("dndx3", e.dndx3, a.dndx3);
    cmp("dndy0", e.dndy0, a.dndy0);
    cmp("dndy1", e.dndy1, a.dndy1);
    cmp("dndy2", e.dndy2, a.dndy2);
    cmp("dndy3", e.dndy3, a.dndy3);
    cmp("det_jac", e.det_jac, a.det_jac);
    cmp("singular", {63'd0, e.singular}, {63'd0, a.singular});
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_WORDS   = 1130;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  b_matrix_board board = new();
  bit  calm = 1'b0;       // no idling on either side while set
  int  quiet_cycles = 0;
  int  sent = 0;

  quad4_strain_displacement uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input monitor, result checker, random output stall and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_stall) board.note_input(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= !calm && ($urandom_range(99) < 15);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d words outstanding", board.pending_q.size());
        $display("quad4_strain_displacement: mismatch");
        $finish;
      end
    end
  end

  // present one word, sometimes with a random gap in front, and hold it until taken
  task automatic send_word(in_word_t w);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(int s, int t, int x0, int x1, int x2, int x3,
                                         int y0, int y1, int y2, int y3);
    in_word_t w;
    w.s_coord = s[15:0];  w.t_coord = t[15:0];
    w.node_x0 = x0[23:0]; w.node_x1 = x1[23:0];
    w.node_x2 = x2[23:0]; w.node_x3 = x3[23:0];
    w.node_y0 = y0[23:0]; w.node_y1 = y1[23:0];
    w.node_y2 = y2[23:0]; w.node_y3 = y3[23:0];
    return w;
  endfunction

  function automatic int rand_nat();
    return $urandom_range(32768) - 16384;
  endfunction

  function automatic int rand_coord();
    return $urandom_range(24'hffffff) - 8388608;
  endfunction

  // a counterclockwise quad around a center, corners jittered
  function automatic in_word_t rand_quad();
    int sc, cx, cy, j;
    int x[4];
    int y[4];
    sc = 1 << $urandom_range(0, 21);
    j  = (sc > 4) ? sc / 4 : 1;
    cx = ($urandom_range(1) != 0) ? rand_coord() / 4 : int'($urandom_range(200)) - 100;
    cy = ($urandom_range(1) != 0) ? rand_coord() / 4 : int'($urandom_range(200)) - 100;
    x[0] = cx - sc; y[0] = cy - sc;
    x[1] = cx + sc; y[1] = cy - sc;
    x[2] = cx + sc; y[2] = cy + sc;
    x[3] = cx - sc; y[3] = cy + sc;
    for (int i = 0; i < NODES; i++) begin
      x[i] += $urandom_range(2 * j) - j;
      y[i] += $urandom_range(2 * j) - j;
    end
    // sometimes collapse the element so the jacobian goes singular
    if ($urandom_range(19) == 0) begin
      x[2] = x[1]; y[2] = y[1]; x[3] = x[0]; y[3] = y[0];
    end
    return make_word(rand_nat(), rand_nat(), x[0], x[1], x[2], x[3],
                     y[0], y[1], y[2], y[3]);
  endfunction

  initial begin
    in_word_t w;
    int       mx, mn;
    mx = 8388607;
    mn = -8388608;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: squares, a skewed quad, center and corners of the (s,t) domain
    send_word(make_word(0, 0, -1, 1, 1, -1, -1, -1, 1, 1));
    send_word(make_word(16384, 16384, -1, 1, 1, -1, -1, -1, 1, 1));
    send_word(make_word(-16384, -16384, -1, 1, 1, -1, -1, -1, 1, 1));
    send_word(make_word(16384, -16384, 0, 10, 10, 0, 0, 0, 10, 10));
    send_word(make_word(-16384, 16384, 0, 10, 12, -3, 0, 1, 9, 11));
    // clockwise ordering gives a negative determinant
    send_word(make_word(5000, -7000, -1, -1, 1, 1, -1, 1, 1, -1));
    // singular: all nodes coincide, all zero, collinear nodes
    send_word(make_word(1234, -4321, 7, 7, 7, 7, -3, -3, -3, -3));
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(-16384, 16384, 0, 1, 2, 3, 0, 2, 4, 6));
    // degenerate corner: at s=t=-1 the jacobian of a triangle-like quad vanishes
    send_word(make_word(-16384, -16384, 0, 0, 5, 0, 0, 0, 5, 5));
    // extreme coordinates, determinant saturates
    send_word(make_word(0, 0, mn, mx, mx, mn, mn, mn, mx, mx));
    send_word(make_word(16384, 16384, mn, mx, mx, mn, mn, mn, mx, mx));
    send_word(make_word(-16384, 0, mx, mn, mn, mx, mn, mn, mx, mx));
    // very thin element, one unit high
    send_word(make_word(0, 0, mn, mx, mx, mn, 0, 0, 1, 1));
    send_word(make_word(16384, -16384, mn, mx, mx, mn, 0, 0, 1, 0));
    // tiny element with one far node
    send_word(make_word(-8192, 8192, 0, 1, mx, 0, 0, 0, mx, 1));
    send_word(make_word(16384, 16384, mx, mx, mx, mx, mn, mn, mn, mx));
    send_word(make_word(-16384, -16384, -1, -1, -1, -1, -1, -1, -1, 0));
    send_word(make_word(-1, 1, 100, -200, 300, -400, 500, -600, 700, -800));
    send_word(make_word(16383, -16383, 3, 1000, 998, 5, -2, 7, 1001, 996));

    // hold the sender until the pipeline has fully drained
    idle_until_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 400 && i < 650);
      if (i == 800) idle_until_drained();
      if ($urandom_range(9) < 8)
        w = rand_quad();
      else
        w = make_word(rand_nat(), rand_nat(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
      send_word(w);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d results, %0d of them singular",
             sent, board.seen, board.singular_seen);
    $display("covered regular, inverted, thin, saturating and singular elements");
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("quad4_strain_displacement: match");
    else
      $display("quad4_strain_displacement: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/q4sd_pkg.sv
hdl/q4sd_mul.sv
hdl/q4sd_front.sv
hdl/q4sd_queue.sv
hdl/q4sd_div.sv
hdl/q4sd_back.sv
hdl/quad4_strain_displacement.sv
tb/sv/tb_top.sv
